// ===== hdl/srs_pkg.sv =====
// Shared types, codes and constants of the servo recipe sequencer.
package srs_pkg;

   localparam int unsigned DEF_RECIPE_DEPTH = 32;

   localparam int unsigned NUM_POS = 6;
   localparam logic [2:0] POS_MAX = 3'd5;

   localparam logic [7:0] DUTY_RESET [NUM_POS] = '{8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7};
   localparam logic [7:0] TICKS_RESET = 8'd2;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_DUTY_0 = 3'd0;
   localparam logic [2:0] CSR_DUTY_1 = 3'd1;
   localparam logic [2:0] CSR_DUTY_2 = 3'd2;
   localparam logic [2:0] CSR_DUTY_3 = 3'd3;
   localparam logic [2:0] CSR_DUTY_4 = 3'd4;
   localparam logic [2:0] CSR_DUTY_5 = 3'd5;
   localparam logic [2:0] CSR_TICKS  = 3'd6;

   // Recipe opcodes, bits 7..5 of a command word.
   localparam logic [2:0] OPC_END      = 3'd0;
   localparam logic [2:0] OPC_MOVE     = 3'd1;
   localparam logic [2:0] OPC_WAIT     = 3'd2;
   localparam logic [2:0] OPC_LOOP     = 3'd4;
   localparam logic [2:0] OPC_LOOP_END = 3'd5;

   // Reported run state codes.
   localparam logic [2:0] RS_INIT  = 3'd0;
   localparam logic [2:0] RS_RUN   = 3'd1;
   localparam logic [2:0] RS_PAUSE = 3'd2;
   localparam logic [2:0] RS_ERROR = 3'd3;
   localparam logic [2:0] RS_END   = 3'd4;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_LOAD       = 3'd1,
      OP_PAUSE      = 3'd2,
      OP_CONTINUE   = 3'd3,
      OP_BEGIN      = 3'd4,
      OP_STEP_LEFT  = 3'd5,
      OP_STEP_RIGHT = 3'd6
   } op_type;

   typedef enum logic [4:0] {
      MODE_INIT  = 5'b00001,
      MODE_RUN   = 5'b00010,
      MODE_PAUSE = 5'b00100,
      MODE_ERROR = 5'b01000,
      MODE_END   = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [4:0] load_address;
      logic [7:0] load_word;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] pwm_duty;
      logic [2:0] servo_position;
      logic [2:0] run_state;
      logic [4:0] recipe_step;
      logic       moving;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0] index;
      logic [7:0] data;
   } csr_payload_type;

   typedef struct packed {
      logic [NUM_POS-1:0][7:0] duty;
      logic [7:0]              ticks_per_step;
   } cfg_type;

   typedef struct packed {
      logic       en;
      logic [4:0] addr;
      logic [7:0] word;
   } store_wr_type;

   function automatic logic [2:0] encode_mode(input mode_type mode);
      logic [2:0] code;
      unique case (mode)
         MODE_INIT:  code = RS_INIT;
         MODE_RUN:   code = RS_RUN;
         MODE_PAUSE: code = RS_PAUSE;
         MODE_ERROR: code = RS_ERROR;
         MODE_END:   code = RS_END;
         default:    code = RS_INIT;
      endcase
      return code;
   endfunction

endpackage

// ===== hdl/srs_chan_if.sv =====
// Valid/ready channel interface used by all ports of the sequencer.
interface srs_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// ===== hdl/srs_csr.sv =====
// Configuration registers: per-position duty values and ticks per step.
module srs_csr (
   input  logic            clock,
   input  logic            reset,
   srs_chan_if.sink        csr_if,
   output srs_pkg::cfg_type cfg
);

   srs_pkg::cfg_type cfg_ff;

   assign csr_if.ready = !reset;
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < srs_pkg::NUM_POS; i++) begin
            cfg_ff.duty[i] <= srs_pkg::DUTY_RESET[i];
         end
         cfg_ff.ticks_per_step <= srs_pkg::TICKS_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.payload.index) inside
            srs_pkg::CSR_DUTY_0, srs_pkg::CSR_DUTY_1, srs_pkg::CSR_DUTY_2,
            srs_pkg::CSR_DUTY_3, srs_pkg::CSR_DUTY_4, srs_pkg::CSR_DUTY_5: begin
               cfg_ff.duty[csr_if.payload.index] <= csr_if.payload.data;
            end
            srs_pkg::CSR_TICKS: begin
               cfg_ff.ticks_per_step <= csr_if.payload.data;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== hdl/srs_store.sv =====
// Recipe memory with a registered read port that always holds the word
// at the next step index.
module srs_store #(
   parameter int unsigned RECIPE_DEPTH = srs_pkg::DEF_RECIPE_DEPTH,
   localparam int unsigned IDX_W = $clog2(RECIPE_DEPTH)
) (
   input  logic                  clock,
   input  srs_pkg::store_wr_type wr,
   input  logic [IDX_W-1:0]      rd_idx,
   output logic [7:0]            rd_word
);

   logic [7:0]       recipe_ff [RECIPE_DEPTH];
   logic [7:0]       rd_word_ff;
   logic [IDX_W-1:0] wr_idx;

   assign wr_idx  = IDX_W'(wr.addr);
   assign rd_word = rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         recipe_ff[wr_idx] <= wr.word;
      end
   end

   // A word loaded at the address being fetched is forwarded directly.
   always_ff @(posedge clock) begin
      if (wr.en && (wr_idx == rd_idx)) begin
         rd_word_ff <= wr.word;
      end else begin
         rd_word_ff <= recipe_ff[rd_idx];
      end
   end

endmodule

// ===== hdl/srs_core.sv =====
// Sequencer state and the single-pass update for one accepted item.
module srs_core #(
   parameter int unsigned RECIPE_DEPTH = srs_pkg::DEF_RECIPE_DEPTH,
   localparam int unsigned IDX_W = $clog2(RECIPE_DEPTH),
   localparam int unsigned STEP_W = $clog2(RECIPE_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  srs_pkg::req_payload_type req,
   input  srs_pkg::cfg_type         cfg,
   input  logic [7:0]               word,
   output srs_pkg::store_wr_type    wr,
   output logic [IDX_W-1:0]         rd_idx,
   output srs_pkg::rsp_payload_type result
);

   srs_pkg::mode_type mode_ff, mode_in;
   logic [2:0]        pos_ff, pos_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [4:0]        rem_ff, rem_in;
   logic [IDX_W-1:0]  org_ff, org_in;
   logic [10:0]       timer_ff, timer_in;

   logic              at_end;
   logic [2:0]        opc;
   logic [4:0]        param;
   logic [2:0]        travel;
   logic [10:0]       move_time;
   logic [STEP_W-1:0] base;

   // An index past the store end executes as an end word.
   assign at_end = (step_ff == STEP_W'(RECIPE_DEPTH));
   assign opc    = at_end ? srs_pkg::OPC_END : word[7:5];
   assign param  = word[4:0];

   assign travel    = (param[2:0] >= pos_ff) ? (param[2:0] - pos_ff) : (pos_ff - param[2:0]);
   assign move_time = 11'(travel) * 11'(cfg.ticks_per_step);

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      org_in   = org_ff;
      timer_in = timer_ff;
      base     = step_ff;
      wr.en    = 1'b0;
      wr.addr  = req.load_address;
      wr.word  = req.load_word;
      if (accept) begin
         unique case (req.operation)
            srs_pkg::OP_TICK: begin
               if (mode_ff == srs_pkg::MODE_RUN) begin
                  if (timer_ff != 11'd0) begin
                     timer_in = timer_ff - 11'd1;
                  end else begin
                     unique case (opc)
                        srs_pkg::OPC_MOVE: begin
                           if (param > 5'(srs_pkg::POS_MAX)) begin
                              mode_in = srs_pkg::MODE_ERROR;
                           end else begin
                              timer_in = move_time;
                              pos_in   = param[2:0];
                           end
                        end
                        srs_pkg::OPC_WAIT: begin
                        end
                        srs_pkg::OPC_LOOP: begin
                           rem_in = param;
                           org_in = step_ff[IDX_W-1:0];
                        end
                        srs_pkg::OPC_LOOP_END: begin
                           if (rem_ff != 5'd0) begin
                              base   = STEP_W'(org_ff);
                              rem_in = rem_ff - 5'd1;
                           end
                        end
                        srs_pkg::OPC_END: begin
                           mode_in = srs_pkg::MODE_END;
                           base    = '0;
                        end
                        default: begin
                        end
                     endcase
                     step_in = (mode_in == srs_pkg::MODE_RUN) ? (base + STEP_W'(1)) : base;
                  end
               end
            end
            srs_pkg::OP_LOAD: begin
               wr.en = (int'(req.load_address) < RECIPE_DEPTH);
            end
            srs_pkg::OP_PAUSE: begin
               if (mode_ff == srs_pkg::MODE_RUN) begin
                  mode_in = srs_pkg::MODE_PAUSE;
               end
            end
            srs_pkg::OP_CONTINUE: begin
               if (mode_ff == srs_pkg::MODE_PAUSE || mode_ff == srs_pkg::MODE_INIT) begin
                  mode_in = srs_pkg::MODE_RUN;
               end
            end
            srs_pkg::OP_BEGIN: begin
               mode_in = srs_pkg::MODE_RUN;
            end
            srs_pkg::OP_STEP_LEFT: begin
               if (mode_ff == srs_pkg::MODE_PAUSE && pos_ff < srs_pkg::POS_MAX) begin
                  pos_in = pos_ff + 3'd1;
               end
            end
            srs_pkg::OP_STEP_RIGHT: begin
               if (mode_ff == srs_pkg::MODE_PAUSE && pos_ff != 3'd0) begin
                  pos_in = pos_ff - 3'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The store prefetches the word at the index that the next item will see.
   assign rd_idx = reset ? '0 : step_in[IDX_W-1:0];

   always_comb begin
      result.pwm_duty       = cfg.duty[pos_in];
      result.servo_position = pos_in;
      result.run_state      = srs_pkg::encode_mode(mode_in);
      result.recipe_step    = 5'(step_in);
      result.moving         = (timer_in != 11'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= srs_pkg::MODE_INIT;
         pos_ff   <= 3'd0;
         step_ff  <= '0;
         rem_ff   <= 5'd0;
         org_ff   <= '0;
         timer_ff <= 11'd0;
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         step_ff  <= step_in;
         rem_ff   <= rem_in;
         org_ff   <= org_in;
         timer_ff <= timer_in;
      end
   end

`ifndef SYNTH
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= srs_pkg::POS_MAX)
      else $error("servo position out of range");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_W'(RECIPE_DEPTH))
      else $error("step index past store end");

   a_timer_mode: assert property (@(posedge clock) disable iff (reset)
      timer_ff != 11'd0 |-> (mode_ff == srs_pkg::MODE_RUN || mode_ff == srs_pkg::MODE_PAUSE))
      else $error("move timer running outside run or pause");

   a_end_rewinds: assert property (@(posedge clock) disable iff (reset)
      mode_ff == srs_pkg::MODE_END |-> step_ff == '0)
      else $error("recipe end without index rewind");

   a_timer_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req.operation == srs_pkg::OP_TICK && mode_ff == srs_pkg::MODE_RUN
       && timer_ff != 11'd0) |=> timer_ff == $past(timer_ff) - 11'd1)
      else $error("move timer did not count down on a tick");
`endif

endmodule

// ===== hdl/servo_recipe_sequencer.sv =====
// Servo recipe sequencer: one servo channel run from a stored command recipe.
//
// Usage: items arrive on req_if (operation, load_address, load_word). Each
// accepted item produces exactly one item on rsp_if with the duty value,
// position, run state, next recipe step and moving flag after the operation.
// A tick runs one recipe word or counts down the move timer; loads fill the
// recipe store; pause, continue, begin and manual steps steer the state.
// csr_if writes the six duty registers and ticks_per_step; it is ready
// whenever reset is low and should be used only while no item is in flight.
// The result is registered and valid in the cycle after acceptance, and one
// item is accepted per cycle unless rsp_if stalls: the whole update is a single
// pass through the decode and the position-distance multiply. The recipe
// memory read is registered and prefetches the next step's word, with load
// forwarding. A result waits in the output register while rsp_if stalls;
// req_if.ready drops only in reset or while that result is held and untaken.
// Reset clears the state to init, position 0, step 0, no move in progress,
// and restores the register defaults. The recipe store is not cleared and
// must be loaded before it is run.
module servo_recipe_sequencer #(
   parameter int unsigned RECIPE_DEPTH = srs_pkg::DEF_RECIPE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   srs_chan_if.sink   req_if,
   srs_chan_if.source rsp_if,
   srs_chan_if.sink   csr_if
);

   localparam int unsigned IDX_W = $clog2(RECIPE_DEPTH);

   srs_pkg::cfg_type         cfg;
   srs_pkg::store_wr_type    wr;
   srs_pkg::rsp_payload_type result;
   srs_pkg::rsp_payload_type rsp_payload_ff;
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rd_idx;
   logic [7:0]               word;
   logic                     accept;

   assign req_if.ready   = !reset && (!rsp_valid_ff || rsp_if.ready);
   assign accept         = req_if.valid && req_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   srs_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   srs_store #(
      .RECIPE_DEPTH (RECIPE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_idx  (rd_idx),
      .rd_word (word)
   );

   srs_core #(
      .RECIPE_DEPTH (RECIPE_DEPTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_if.payload),
      .cfg    (cfg),
      .word   (word),
      .wr     (wr),
      .rd_idx (rd_idx),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= result;
      end
   end

endmodule
